>>> rtl/core/dbp_pkg.sv
// ----------------------------------------------------------------------------
// dbp_pkg
// Shared widths, register indexes and stage controls for the depth pixel
// backprojection pipeline.
// ----------------------------------------------------------------------------
package dbp_pkg;

    // Fixed port widths
    localparam int COORD_W = 10;
    localparam int DEPTH_W = 16;
    localparam int COLOR_W = 8;
    localparam int POINT_W = 32;
    localparam int CFG_AW  = 3;
    localparam int CFG_DW  = 24;

    // Significant bits of the position and depth fields
    localparam int COORD_BITS = 10;
    localparam int DEPTH_BITS = 16;

    localparam logic [COORD_W-1:0] COORD_MASK = COORD_W'((64'd1 << COORD_BITS) - 64'd1);
    localparam logic [DEPTH_W-1:0] DEPTH_MASK = DEPTH_W'((64'd1 << DEPTH_BITS) - 64'd1);

    // Arithmetic widths
    localparam int SCALE_W = 24;
    localparam int PRINC_W = 16;
    localparam int INVF_W  = 24;
    localparam int ZQ24_W  = DEPTH_W + SCALE_W;   // 40
    localparam int MAG_W   = 16;
    localparam int PROD1_W = MAG_W + INVF_W;      // 40
    localparam int RATIO_W = PROD1_W - 12;        // 28
    localparam int PROD2_W = RATIO_W + POINT_W;   // 60

    // Number of pipeline stages (input register through output register)
    localparam int NSTAGE = 6;

    // Register indexes
    typedef enum logic [CFG_AW-1:0] {
        REG_DEPTH_SCALE = 3'd0,
        REG_PRINC_X     = 3'd1,
        REG_PRINC_Y     = 3'd2,
        REG_INV_FX      = 3'd3,
        REG_INV_FY      = 3'd4
    } t_cfg_idx;

    // Reset values
    localparam logic [SCALE_W-1:0] RST_DEPTH_SCALE = 24'd16777;
    localparam logic [PRINC_W-1:0] RST_PRINC_X     = 16'd5208;
    localparam logic [PRINC_W-1:0] RST_PRINC_Y     = 16'd4056;
    localparam logic [INVF_W-1:0]  RST_INV_FX      = 24'd32388;
    localparam logic [INVF_W-1:0]  RST_INV_FY      = 24'd32326;

    // Per-stage load enables
    typedef struct packed {
        logic s0;
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } t_stage_en;

endpackage

>>> rtl/core/depth_pixel_backprojection_top.sv
// ----------------------------------------------------------------------------
// depth_pixel_backprojection_top
// Pinhole backprojection of depth pixels into colored Q16.16 3D points.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake                  | Payload
//  --------+-----------+----------------------------+---------------------------------
//  pixel   | in        | i_pix_valid / o_pix_ready  | row, col, depth, blue/green/red
//  point   | out       | o_pt_valid  / i_pt_ready   | x, y, z, blue/green/red
//  config  | in        | i_cfg_we (no wait)         | i_cfg_addr, i_cfg_wdata
//
//  Throughput is one pixel per clock unless the point side stalls. Six
//  register stages, which the pixel passes through in order: input register,
//  depth multiply, z rounding plus offset multiply, ratio rounding, 28x32 ratio*z
//  multiply, round/saturate into the output reg, which drives o_pt_valid.
//  Zero-depth pixels are accepted and leave as a bubble (no transaction out).
//  Each stage advances when the stage after it is empty or moving, so bubbles
//  collapse under back-pressure and a stall loses or repeats nothing.
//  Reset (synchronous, active low) clears the stage valid bits and loads the
//  configuration registers with their defaults.
// ----------------------------------------------------------------------------
module depth_pixel_backprojection_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,

    // configuration write port
    input  logic                               i_cfg_we,
    input  logic [dbp_pkg::CFG_AW-1:0]         i_cfg_addr,
    input  logic [dbp_pkg::CFG_DW-1:0]         i_cfg_wdata,

    // pixel input
    input  logic                               i_pix_valid,
    output logic                               o_pix_ready,
    input  logic [dbp_pkg::COORD_W-1:0]        i_pixel_row,
    input  logic [dbp_pkg::COORD_W-1:0]        i_pixel_col,
    input  logic [dbp_pkg::DEPTH_W-1:0]        i_depth_raw,
    input  logic [dbp_pkg::COLOR_W-1:0]        i_blue_in,
    input  logic [dbp_pkg::COLOR_W-1:0]        i_green_in,
    input  logic [dbp_pkg::COLOR_W-1:0]        i_red_in,

    // point output
    output logic                               o_pt_valid,
    input  logic                               i_pt_ready,
    output logic signed [dbp_pkg::POINT_W-1:0] o_point_x,
    output logic signed [dbp_pkg::POINT_W-1:0] o_point_y,
    output logic [dbp_pkg::POINT_W-1:0]        o_point_z,
    output logic [dbp_pkg::COLOR_W-1:0]        o_blue_out,
    output logic [dbp_pkg::COLOR_W-1:0]        o_green_out,
    output logic [dbp_pkg::COLOR_W-1:0]        o_red_out
);

    localparam int NS   = dbp_pkg::NSTAGE;
    localparam int BGRW = 3 * dbp_pkg::COLOR_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [dbp_pkg::SCALE_W-1:0] r_depth_scale;
    logic [dbp_pkg::PRINC_W-1:0] r_princ_x;
    logic [dbp_pkg::PRINC_W-1:0] r_princ_y;
    logic [dbp_pkg::INVF_W-1:0]  r_inv_fx;
    logic [dbp_pkg::INVF_W-1:0]  r_inv_fy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth_scale <= dbp_pkg::RST_DEPTH_SCALE;
            r_princ_x     <= dbp_pkg::RST_PRINC_X;
            r_princ_y     <= dbp_pkg::RST_PRINC_Y;
            r_inv_fx      <= dbp_pkg::RST_INV_FX;
            r_inv_fy      <= dbp_pkg::RST_INV_FY;
        end else if (i_cfg_we) begin
            case (dbp_pkg::t_cfg_idx'(i_cfg_addr))
                dbp_pkg::REG_DEPTH_SCALE: r_depth_scale <= i_cfg_wdata;
                dbp_pkg::REG_PRINC_X:     r_princ_x <= i_cfg_wdata[dbp_pkg::PRINC_W-1:0];
                dbp_pkg::REG_PRINC_Y:     r_princ_y <= i_cfg_wdata[dbp_pkg::PRINC_W-1:0];
                dbp_pkg::REG_INV_FX:      r_inv_fx  <= i_cfg_wdata;
                dbp_pkg::REG_INV_FY:      r_inv_fy  <= i_cfg_wdata;
                default: ;   // unmapped index: write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage flow control: a stage loads when it is empty or its
    // successor is loading (or, for the output stage, being drained).
    // ------------------------------------------------------------------
    logic [NS-1:0]      r_vld;
    logic [NS-1:0]      n_rdy;
    dbp_pkg::t_stage_en n_en;

    always_comb begin
        n_rdy[NS-1] = !r_vld[NS-1] || i_pt_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            n_rdy[k] = !r_vld[k] || n_rdy[k+1];
        end
        n_en.s0 = n_rdy[0];
        n_en.s1 = n_rdy[1];
        n_en.s2 = n_rdy[2];
        n_en.s3 = n_rdy[3];
        n_en.s4 = n_rdy[4];
        n_en.s5 = n_rdy[5];
    end

    assign o_pix_ready = n_rdy[0];

    logic [dbp_pkg::DEPTH_W-1:0] n_depth;
    assign n_depth = i_depth_raw & dbp_pkg::DEPTH_MASK;

    // Zero depth enters as a bubble
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (n_rdy[0]) begin
                r_vld[0] <= i_pix_valid && (n_depth != '0);
            end
            for (int k = 1; k < NS; k++) begin
                if (n_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_pt_valid = r_vld[NS-1];

    // ------------------------------------------------------------------
    // Depth path
    // ------------------------------------------------------------------
    logic [dbp_pkg::COORD_W-1:0] r0_row;
    logic [dbp_pkg::COORD_W-1:0] r0_col;
    logic [dbp_pkg::DEPTH_W-1:0] r0_depth;
    logic [dbp_pkg::ZQ24_W-1:0]  r1_zq24;
    logic [dbp_pkg::POINT_W-1:0] r2_zq16;
    logic [dbp_pkg::POINT_W-1:0] r3_zq16;
    logic [dbp_pkg::POINT_W-1:0] r4_zq16;
    logic [dbp_pkg::POINT_W-1:0] r5_zq16;
    logic [BGRW-1:0]             r_bgr [NS];

    // z = round(zq24 / 256), saturated to 32 bits
    logic [dbp_pkg::ZQ24_W:0]    n_zsum;
    logic [dbp_pkg::POINT_W-1:0] n_zq16;

    always_comb begin
        n_zsum = {1'b0, r1_zq24} + (dbp_pkg::ZQ24_W + 1)'(128);
        if (n_zsum[dbp_pkg::ZQ24_W:8] > 33'h0FFFFFFFF) begin
            n_zq16 = '1;
        end else begin
            n_zq16 = n_zsum[dbp_pkg::POINT_W+7:8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en.s0) begin
            r0_row   <= i_pixel_row & dbp_pkg::COORD_MASK;
            r0_col   <= i_pixel_col & dbp_pkg::COORD_MASK;
            r0_depth <= n_depth;
            r_bgr[0] <= {i_blue_in, i_green_in, i_red_in};
        end
        if (n_en.s1) begin
            r1_zq24  <= r0_depth * r_depth_scale;
            r_bgr[1] <= r_bgr[0];
        end
        if (n_en.s2) begin
            r2_zq16  <= n_zq16;
            r_bgr[2] <= r_bgr[1];
        end
        if (n_en.s3) begin
            r3_zq16  <= r2_zq16;
            r_bgr[3] <= r_bgr[2];
        end
        if (n_en.s4) begin
            r4_zq16  <= r3_zq16;
            r_bgr[4] <= r_bgr[3];
        end
        if (n_en.s5) begin
            r5_zq16  <= r4_zq16;
            r_bgr[5] <= r_bgr[4];
        end
    end

    // ------------------------------------------------------------------
    // Lateral coordinates
    // ------------------------------------------------------------------
    dbp_lateral u_lat_x (
        .i_clk       (i_clk),
        .i_en        (n_en),
        .i_pix       (r0_col),
        .i_principal (r_princ_x),
        .i_inv_f     (r_inv_fx),
        .i_zq16      (r3_zq16),
        .o_point     (o_point_x)
    );

    dbp_lateral u_lat_y (
        .i_clk       (i_clk),
        .i_en        (n_en),
        .i_pix       (r0_row),
        .i_principal (r_princ_y),
        .i_inv_f     (r_inv_fy),
        .i_zq16      (r3_zq16),
        .o_point     (o_point_y)
    );

    assign o_point_z   = r5_zq16;
    assign o_blue_out  = r_bgr[NS-1][BGRW-1 -: dbp_pkg::COLOR_W];
    assign o_green_out = r_bgr[NS-1][dbp_pkg::COLOR_W +: dbp_pkg::COLOR_W];
    assign o_red_out   = r_bgr[NS-1][dbp_pkg::COLOR_W-1:0];

endmodule

>>> rtl/core/dbp_lateral.sv
// ----------------------------------------------------------------------------
// dbp_lateral
// Lateral coordinate datapath: (pix*16 - principal) * inv_focal * z, rounded
// half away from zero and saturated to signed Q16.16. Stages 1 to 5.
// ----------------------------------------------------------------------------
module dbp_lateral (
    input  logic                              i_clk,
    input  dbp_pkg::t_stage_en                i_en,
    input  logic [dbp_pkg::COORD_W-1:0]       i_pix,       // stage 0 value
    input  logic [dbp_pkg::PRINC_W-1:0]       i_principal,
    input  logic [dbp_pkg::INVF_W-1:0]        i_inv_f,
    input  logic [dbp_pkg::POINT_W-1:0]       i_zq16,      // stage 3 value
    output logic signed [dbp_pkg::POINT_W-1:0] o_point
);

    localparam int DIFF_W = dbp_pkg::PRINC_W + 1;

    logic [DIFF_W-1:0]              n_diff;
    logic [dbp_pkg::MAG_W-1:0]      n_mag;
    logic [dbp_pkg::PROD1_W-1:0]    n_rsum;
    logic [dbp_pkg::PROD2_W-1:0]    n_qsum;
    logic [dbp_pkg::PROD2_W-17:0]   n_q;
    logic [dbp_pkg::POINT_W-1:0]    n_pos;
    logic [dbp_pkg::POINT_W-1:0]    n_negq;

    logic [dbp_pkg::MAG_W-1:0]      r1_mag;
    logic                           r1_neg;
    logic [dbp_pkg::PROD1_W-1:0]    r2_prod;
    logic                           r2_neg;
    logic [dbp_pkg::RATIO_W-1:0]    r3_ratio;
    logic                           r3_neg;
    logic [dbp_pkg::PROD2_W-1:0]    r4_prod;
    logic                           r4_neg;
    logic signed [dbp_pkg::POINT_W-1:0] r5_point;

    // Signed offset from the principal point, as sign and magnitude
    always_comb begin
        n_diff = DIFF_W'({i_pix, 4'b0000}) - {1'b0, i_principal};
        n_mag  = n_diff[DIFF_W-1] ? dbp_pkg::MAG_W'(-n_diff) : n_diff[dbp_pkg::MAG_W-1:0];
    end

    assign n_rsum = r2_prod + dbp_pkg::PROD1_W'(2048);

    // Final rounding and saturation
    always_comb begin
        n_qsum = r4_prod + dbp_pkg::PROD2_W'(32768);
        n_q    = n_qsum[dbp_pkg::PROD2_W-1:16];
        if (n_q > 44'h0007FFFFFFF) begin
            n_pos = 32'h7FFFFFFF;
        end else begin
            n_pos = n_q[dbp_pkg::POINT_W-1:0];
        end
        if (n_q > 44'h00080000000) begin
            n_negq = 32'h80000000;
        end else begin
            n_negq = n_q[dbp_pkg::POINT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r1_mag <= n_mag;
            r1_neg <= n_diff[DIFF_W-1];
        end
        if (i_en.s2) begin
            r2_prod <= r1_mag * i_inv_f;
            r2_neg  <= r1_neg;
        end
        if (i_en.s3) begin
            r3_ratio <= n_rsum[dbp_pkg::PROD1_W-1:12];
            r3_neg   <= r2_neg;
        end
        if (i_en.s4) begin
            r4_prod <= r3_ratio * i_zq16;
            r4_neg  <= r3_neg;
        end
        if (i_en.s5) begin
            r5_point <= r4_neg ? $signed(32'd0 - n_negq) : $signed(n_pos);
        end
    end

    assign o_point = r5_point;

endmodule

>>> sim/dbp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbp_checker
// Watches the pixel, point and register write channels of the depth pixel
// backprojection block. Keeps a shadow copy of the camera registers, works
// out the 3D point each accepted pixel should give, and compares the points
// that leave the block, in order, field by field.
// ----------------------------------------------------------------------------
module dbp_checker
    import dbp_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,

    input  logic                      i_cfg_we,
    input  logic [CFG_AW-1:0]         i_cfg_addr,
    input  logic [CFG_DW-1:0]         i_cfg_wdata,

    input  logic                      i_pix_valid,
    input  logic                      i_pix_ready,
    input  logic [COORD_W-1:0]        i_pixel_row,
    input  logic [COORD_W-1:0]        i_pixel_col,
    input  logic [DEPTH_W-1:0]        i_depth_raw,
    input  logic [COLOR_W-1:0]        i_blue_in,
    input  logic [COLOR_W-1:0]        i_green_in,
    input  logic [COLOR_W-1:0]        i_red_in,

    input  logic                      i_pt_valid,
    input  logic                      i_pt_ready,
    input  logic signed [POINT_W-1:0] i_point_x,
    input  logic signed [POINT_W-1:0] i_point_y,
    input  logic [POINT_W-1:0]        i_point_z,
    input  logic [COLOR_W-1:0]        i_blue_out,
    input  logic [COLOR_W-1:0]        i_green_out,
    input  logic [COLOR_W-1:0]        i_red_out,

    output int                        o_points_pending,
    output int                        o_mismatches
);

    typedef struct packed {
        logic [POINT_W-1:0] x;
        logic [POINT_W-1:0] y;
        logic [POINT_W-1:0] z;
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] red;
    } t_point;

    logic [SCALE_W-1:0] depth_scale;
    logic [PRINC_W-1:0] center_x;
    logic [PRINC_W-1:0] center_y;
    logic [INVF_W-1:0]  inv_fx;
    logic [INVF_W-1:0]  inv_fy;

    t_point expected_points[$];
    int     mismatch_cnt = 0;

    assign o_mismatches = mismatch_cnt;

    // One lateral axis: (pix*16 - center) * inv_f * z, sign-magnitude,
    // rounded half away from zero, saturated to signed Q16.16.
    function automatic logic [POINT_W-1:0] lateral_coord(
        input logic [COORD_W-1:0] pix,
        input logic [PRINC_W-1:0] center,
        input logic [INVF_W-1:0]  inv_f,
        input logic [POINT_W-1:0] zq16
    );
        logic [63:0] pix16;
        logic [63:0] mag;
        logic [63:0] ratio;
        logic [63:0] q;
        logic        neg;
        pix16 = 64'(pix & COORD_MASK) << 4;
        neg   = pix16 < 64'(center);
        mag   = neg ? 64'(center) - pix16 : pix16 - 64'(center);
        ratio = (mag * 64'(inv_f) + 64'd2048) >> 12;
        q     = (ratio * 64'(zq16) + 64'd32768) >> 16;
        if (!neg) begin
            return (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
        end
        if (q > 64'h8000_0000) begin
            q = 64'h8000_0000;
        end
        q = 64'd0 - q;
        return q[31:0];
    endfunction

    function automatic t_point project_pixel(
        input logic [COORD_W-1:0] row,
        input logic [COORD_W-1:0] col,
        input logic [DEPTH_W-1:0] depth,
        input logic [COLOR_W-1:0] blue,
        input logic [COLOR_W-1:0] green,
        input logic [COLOR_W-1:0] red
    );
        t_point      pt;
        logic [63:0] zq16;
        zq16 = (64'(depth & DEPTH_MASK) * 64'(depth_scale) + 64'd128) >> 8;
        if (zq16 > 64'hFFFF_FFFF) begin
            zq16 = 64'hFFFF_FFFF;
        end
        pt.x     = lateral_coord(col, center_x, inv_fx, zq16[31:0]);
        pt.y     = lateral_coord(row, center_y, inv_fy, zq16[31:0]);
        pt.z     = zq16[31:0];
        pt.blue  = blue;
        pt.green = green;
        pt.red   = red;
        return pt;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t dbp_checker: %s got %h expected %h", $time, what, got, want);
        mismatch_cnt++;
    endtask

    always @(posedge i_clk) begin : monitor
        t_point seen;
        t_point want;
        if (!i_rst_n) begin
            depth_scale = RST_DEPTH_SCALE;
            center_x    = RST_PRINC_X;
            center_y    = RST_PRINC_Y;
            inv_fx      = RST_INV_FX;
            inv_fy      = RST_INV_FY;
            expected_points.delete();
        end else begin
            // outgoing point first, so a point never meets a pixel taken this edge
            if (i_pt_valid && i_pt_ready) begin
                seen.x     = i_point_x;
                seen.y     = i_point_y;
                seen.z     = i_point_z;
                seen.blue  = i_blue_out;
                seen.green = i_green_out;
                seen.red   = i_red_out;
                if (expected_points.size() == 0) begin
                    report_mismatch("point with no pixel pending, x", seen.x, '0);
                end else begin
                    want = expected_points.pop_front();
                    if (seen.x !== want.x) report_mismatch("point_x", seen.x, want.x);
                    if (seen.y !== want.y) report_mismatch("point_y", seen.y, want.y);
                    if (seen.z !== want.z) report_mismatch("point_z", seen.z, want.z);
                    if (seen.blue !== want.blue)
                        report_mismatch("blue_out", 32'(seen.blue), 32'(want.blue));
                    if (seen.green !== want.green)
                        report_mismatch("green_out", 32'(seen.green), 32'(want.green));
                    if (seen.red !== want.red)
                        report_mismatch("red_out", 32'(seen.red), 32'(want.red));
                end
            end
            // zero depth is taken but yields no point
            if (i_pix_valid && i_pix_ready && (i_depth_raw & DEPTH_MASK) != '0) begin
                expected_points.insert(expected_points.size(),
                    project_pixel(i_pixel_row, i_pixel_col,
                                  i_depth_raw, i_blue_in, i_green_in, i_red_in));
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_DEPTH_SCALE: depth_scale = i_cfg_wdata[SCALE_W-1:0];
                    REG_PRINC_X:     center_x    = i_cfg_wdata[PRINC_W-1:0];
                    REG_PRINC_Y:     center_y    = i_cfg_wdata[PRINC_W-1:0];
                    REG_INV_FX:      inv_fx      = i_cfg_wdata[INVF_W-1:0];
                    REG_INV_FY:      inv_fy      = i_cfg_wdata[INVF_W-1:0];
                    default: ;
                endcase
            end
        end
        o_points_pending <= expected_points.size();
    end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the depth pixel backprojection block. Drives
// pixels through the valid/ready input, pulls points with a randomly
// stalling sink, and reprograms the camera registers between phases while
// the pipe is empty. dbp_checker does all prediction and comparison.
// ----------------------------------------------------------------------------
module tb_top;
    import dbp_pkg::*;

    // Run shape
    localparam int N_RANDOM_PHASES  = 6;
    localparam int ITEMS_PER_PHASE  = 137;
    localparam int QUIET_PHASE      = 1;     // no idling on either side
    localparam int PAUSE_PHASE      = 2;     // sender drains the pipe mid-phase
    localparam int SETTLE_CYCLES    = 12;    // pipe is 6 deep, allow margin
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int LONG_HOLD_CYCLES = 60;
    localparam int HOLD_AT_FIRST    = 150;   // sink backs off after this many points
    localparam int HOLD_AT_SECOND   = 500;

    // Addresses above the last register, writes there must be dropped
    localparam logic [CFG_AW-1:0] REG_FIRST_SPARE = 3'd5;

    localparam logic [COORD_W-1:0] COORD_MAX = COORD_MASK;
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_MASK;
    localparam logic [CFG_DW-1:0]  Q24_MAX   = 24'hFF_FFFF;
    localparam logic [CFG_DW-1:0]  Q4_MAX    = 24'h00_FFFF;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [DEPTH_W-1:0] depth;
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] red;
    } t_pixel;

    // ------------------------------------------------------------------
    // Clock, block inputs (all known from time zero), block outputs
    // ------------------------------------------------------------------
    logic clk;

    logic               rst_n     = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [CFG_AW-1:0]  cfg_addr  = '0;
    logic [CFG_DW-1:0]  cfg_wdata = '0;
    logic               pix_valid = 1'b0;
    logic [COORD_W-1:0] pix_row   = '0;
    logic [COORD_W-1:0] pix_col   = '0;
    logic [DEPTH_W-1:0] pix_depth = '0;
    logic [COLOR_W-1:0] pix_blue  = '0;
    logic [COLOR_W-1:0] pix_green = '0;
    logic [COLOR_W-1:0] pix_red   = '0;
    logic               pt_ready  = 1'b0;

    logic                      pix_ready;
    logic                      pt_valid;
    logic signed [POINT_W-1:0] point_x;
    logic signed [POINT_W-1:0] point_y;
    logic [POINT_W-1:0]        point_z;
    logic [COLOR_W-1:0]        pt_blue;
    logic [COLOR_W-1:0]        pt_green;
    logic [COLOR_W-1:0]        pt_red;

    int points_pending;
    int mismatches;
    int idle_cycles = 0;
    bit quiet       = 1'b0;   // when set, neither side inserts gaps

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    depth_pixel_backprojection_top uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata),
        .i_pix_valid (pix_valid),
        .o_pix_ready (pix_ready),
        .i_pixel_row (pix_row),
        .i_pixel_col (pix_col),
        .i_depth_raw (pix_depth),
        .i_blue_in   (pix_blue),
        .i_green_in  (pix_green),
        .i_red_in    (pix_red),
        .o_pt_valid  (pt_valid),
        .i_pt_ready  (pt_ready),
        .o_point_x   (point_x),
        .o_point_y   (point_y),
        .o_point_z   (point_z),
        .o_blue_out  (pt_blue),
        .o_green_out (pt_green),
        .o_red_out   (pt_red)
    );

    dbp_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_addr       (cfg_addr),
        .i_cfg_wdata      (cfg_wdata),
        .i_pix_valid      (pix_valid),
        .i_pix_ready      (pix_ready),
        .i_pixel_row      (pix_row),
        .i_pixel_col      (pix_col),
        .i_depth_raw      (pix_depth),
        .i_blue_in        (pix_blue),
        .i_green_in       (pix_green),
        .i_red_in         (pix_red),
        .i_pt_valid       (pt_valid),
        .i_pt_ready       (pt_ready),
        .i_point_x        (point_x),
        .i_point_y        (point_y),
        .i_point_z        (point_z),
        .i_blue_out       (pt_blue),
        .i_green_out      (pt_green),
        .i_red_out        (pt_red),
        .o_points_pending (points_pending),
        .o_mismatches     (mismatches)
    );

    // ------------------------------------------------------------------
    // Watchdog: counts edges with no transaction on either data channel
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n || (pix_valid && pix_ready) || (pt_valid && pt_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    function automatic t_pixel make_pixel(
        input logic [COORD_W-1:0] row,
        input logic [COORD_W-1:0] col,
        input logic [DEPTH_W-1:0] depth,
        input logic [COLOR_W-1:0] blue,
        input logic [COLOR_W-1:0] green,
        input logic [COLOR_W-1:0] red
    );
        t_pixel p;
        p.row   = row;
        p.col   = col;
        p.depth = depth;
        p.blue  = blue;
        p.green = green;
        p.red   = red;
        return p;
    endfunction

    // Edges of the image and missing depth show up often; the rest is uniform.
    function automatic t_pixel random_pixel();
        t_pixel p;
        case ($urandom_range(0, 7))
            0:       p.row = '0;
            1:       p.row = COORD_MAX;
            default: p.row = COORD_W'($urandom);
        endcase
        case ($urandom_range(0, 7))
            0:       p.col = '0;
            1:       p.col = COORD_MAX;
            default: p.col = COORD_W'($urandom);
        endcase
        case ($urandom_range(0, 9))
            0, 1:    p.depth = '0;
            2:       p.depth = DEPTH_MAX;
            3, 4:    p.depth = DEPTH_W'($urandom_range(1, 255));
            default: p.depth = DEPTH_W'($urandom_range(1, int'(DEPTH_MAX)));
        endcase
        p.blue  = COLOR_W'($urandom);
        p.green = COLOR_W'($urandom);
        p.red   = COLOR_W'($urandom);
        return p;
    endfunction

    // Register value for a random phase: zero, all ones, power-on value or uniform.
    function automatic logic [CFG_DW-1:0] pick_reg_value(input int width,
                                                         input logic [CFG_DW-1:0] dflt);
        logic [CFG_DW-1:0] mask;
        mask = CFG_DW'((64'd1 << width) - 64'd1);
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return mask;
            2:       return dflt;
            default: return CFG_DW'($urandom) & mask;
        endcase
    endfunction

    // Offer one pixel, hold it until the block takes it.
    task automatic send_pixel(input t_pixel p);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            pix_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix_row   <= p.row;
        pix_col   <= p.col;
        pix_depth <= p.depth;
        pix_blue  <= p.blue;
        pix_green <= p.green;
        pix_red   <= p.red;
        do @(posedge clk); while (!pix_ready);
    endtask

    // Back-to-back writes keep cfg_we high; the caller drops it.
    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= data;
        @(posedge clk);
    endtask

    // The first edge lets the pending count catch up with the last pixel;
    // settle covers zero-depth bubbles still walking down the pipe.
    task automatic wait_drained();
        @(posedge clk);
        while (points_pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Reprogram the camera only with the pipe empty.
    task automatic load_setup(input logic [CFG_DW-1:0] scale,
                              input logic [CFG_DW-1:0] cx,
                              input logic [CFG_DW-1:0] cy,
                              input logic [CFG_DW-1:0] ifx,
                              input logic [CFG_DW-1:0] ify);
        pix_valid <= 1'b0;
        wait_drained();
        write_reg(REG_DEPTH_SCALE, scale);
        write_reg(REG_PRINC_X, cx);
        write_reg(REG_PRINC_Y, cy);
        write_reg(REG_INV_FX, ifx);
        write_reg(REG_INV_FY, ify);
        // junk to the unmapped addresses must leave everything alone
        for (int a = int'(REG_FIRST_SPARE); a < (1 << CFG_AW); a++) begin
            write_reg(CFG_AW'(a), CFG_DW'($urandom));
        end
        cfg_we <= 1'b0;
    endtask

    // Two opposite image corners at full depth, then a unit depth at row 0, last column.
    task automatic send_corners();
        send_pixel(make_pixel('0, '0, DEPTH_MAX, 8'h00, 8'h00, 8'h00));
        send_pixel(make_pixel(COORD_MAX, COORD_MAX, DEPTH_MAX, 8'hFF, 8'hFF, 8'hFF));
        send_pixel(make_pixel('0, COORD_MAX, 16'd1, 8'h12, 8'h34, 8'h56));
    endtask

    // ------------------------------------------------------------------
    // Point sink: random stalls per transaction, plus two long hold-offs
    // that fill the pipe and push back on the pixel side.
    // ------------------------------------------------------------------
    initial begin : point_sink
        int gap;
        int points_taken;
        points_taken = 0;
        do @(posedge clk); while (!rst_n);
        forever begin
            if (points_taken == HOLD_AT_FIRST || points_taken == HOLD_AT_SECOND) begin
                pt_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
            end
            gap = quiet ? 0 : $urandom_range(0, 3);
            if (gap > 0) begin
                pt_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pt_ready <= 1'b1;
            do @(posedge clk); while (!pt_valid);
            points_taken++;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and verdict
    // ------------------------------------------------------------------
    initial begin : stimulus
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Power-on camera: corners, missing depth, both sides of the
        // principal point, alternating bit patterns.
        send_pixel(make_pixel('0, '0, 16'd1, 8'h00, 8'h00, 8'h00));
        send_pixel(make_pixel(COORD_MAX, COORD_MAX, DEPTH_MAX, 8'hFF, 8'hFF, 8'hFF));
        send_pixel(make_pixel('0, COORD_MAX, DEPTH_MAX, 8'hAA, 8'h55, 8'h0F));
        send_pixel(make_pixel(COORD_MAX, '0, 16'd1, 8'hF0, 8'h0F, 8'hA5));
        send_pixel(make_pixel(10'd5, 10'd7, '0, 8'h11, 8'h22, 8'h33));
        send_pixel(make_pixel(COORD_MAX, COORD_MAX, '0, 8'hFF, 8'hFF, 8'hFF));
        send_pixel(make_pixel(10'd253, 10'd325, 16'd1000, 8'h01, 8'h02, 8'h03));
        send_pixel(make_pixel(10'd254, 10'd326, 16'd1000, 8'hFE, 8'hFD, 8'hFC));
        send_pixel(make_pixel(10'd512, 10'd512, 16'h8000, 8'h80, 8'h80, 8'h80));
        send_pixel(make_pixel(10'h155, 10'h2AA, 16'h5555, 8'h55, 8'hAA, 8'h5A));
        send_pixel(make_pixel(10'h2AA, 10'h155, 16'hAAAA, 8'hAA, 8'h55, 8'hA5));

        // Everything at full scale: principal point far right/bottom,
        // so lateral coordinates saturate negative.
        load_setup(Q24_MAX, Q4_MAX, Q4_MAX, Q24_MAX, Q24_MAX);
        send_corners();

        // Smallest useful settings: principal point at the origin.
        load_setup(24'd1, '0, '0, 24'd1, 24'd1);
        send_corners();

        // Zero scale and zero reciprocals: every product collapses to zero.
        load_setup('0, Q4_MAX, '0, '0, '0);
        send_corners();

        // Origin principal point with full gains: positive saturation.
        load_setup(Q24_MAX, '0, '0, Q24_MAX, Q24_MAX);
        send_corners();

        // Random camera setups, each with a burst of pixels.
        for (int phase = 0; phase < N_RANDOM_PHASES; phase++) begin
            load_setup(pick_reg_value(SCALE_W, RST_DEPTH_SCALE),
                       pick_reg_value(PRINC_W, RST_PRINC_X),
                       pick_reg_value(PRINC_W, RST_PRINC_Y),
                       pick_reg_value(INVF_W, RST_INV_FX),
                       pick_reg_value(INVF_W, RST_INV_FY));
            quiet = (phase == QUIET_PHASE);
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (phase == PAUSE_PHASE && k == ITEMS_PER_PHASE / 2) begin
                    // stop offering until every point in flight has come out
                    pix_valid <= 1'b0;
                    wait_drained();
                end
                send_pixel(random_pixel());
            end
            quiet = 1'b0;
        end

        // Final drain, then the verdict.
        pix_valid <= 1'b0;
        wait_drained();
        if (mismatches == 0 && points_pending == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
